### hdl/ialu_pkg.sv
// Shared types and constants for the indexed array list engine.
`timescale 1ns / 1ps
package ialu_pkg;

	localparam int OP_W   = 3;
	localparam int POS_W  = 9;
	localparam int DATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_POP    = 3'd2,
		OP_REMOVE = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_LOAD,
		CMD_SHIFT
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t                 cmd;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

endpackage

### hdl/ialu_cell.sv
// One list cell: a stored element plus a read lane that shifts toward the head.
`timescale 1ns / 1ps
module ialu_cell #(
	parameter int IDX_W = 9,
	parameter int INDEX = 0
) (
	input  logic                                clk,
	input  ialu_pkg::cell_ctrl_t                ctrl,
	input  logic [IDX_W-1:0]                    pos,
	input  logic signed [ialu_pkg::DATA_W-1:0]  prev_data,
	input  logic signed [ialu_pkg::DATA_W-1:0]  next_data,
	input  logic signed [ialu_pkg::DATA_W-1:0]  next_lane,
	output logic signed [ialu_pkg::DATA_W-1:0]  data,
	output logic signed [ialu_pkg::DATA_W-1:0]  lane
);
	import ialu_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] lane_q;

	// Shift elements for insert/remove; load or advance the read lane
	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CMD_INSERT: begin
				if (MY_IDX == pos) begin
					data_q <= ctrl.value;
				end else if (MY_IDX > pos) begin
					data_q <= prev_data;
				end
			end
			CMD_REMOVE: begin
				if (MY_IDX >= pos) begin
					data_q <= next_data;
				end
			end
			CMD_LOAD: begin
				lane_q <= data_q;
			end
			CMD_SHIFT: begin
				lane_q <= next_lane;
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;
	assign lane = lane_q;

endmodule

### hdl/indexed_array_list_engine_unit.sv
// Top level of the indexed array list engine: control, length and the cell row.
//
// Usage:
//   Drive opcode, position and value with start high; the command is taken at
//   a rising edge where start is high and busy is low. Every command returns
//   one result on status, read_value and count, marked by done for exactly one
//   cycle; the receiver cannot hold it off.
//   Append, insert, remove last and remove at index take no walk: the
//   result shows the cycle after the transfer and busy stays low, so one
//   command per cycle is taken. The whole row of cells shifts at once.
//   A read that is in range copies every element into the read lanes and
//   walks them toward cell 0, one cell a cycle: busy is high until the element
//   at position reaches cell 0, and the result shows in the cycle busy falls.
//   Rejected commands (bad index, empty, full, unused opcode) answer the cycle
//   after the transfer with status high and change nothing.
//   Reset clears the length and the control state; element contents stay
//   undefined until written, and only written entries can ever be read.
`timescale 1ns / 1ps
module indexed_array_list_engine_unit #(
	parameter int CAPACITY = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ialu_pkg::OP_W-1:0]           opcode,
	input  logic [ialu_pkg::POS_W-1:0]          position,
	input  logic signed [ialu_pkg::DATA_W-1:0]  value,
	output logic                                done,
	output logic                                status,
	output logic signed [ialu_pkg::DATA_W-1:0]  read_value,
	output logic [ialu_pkg::POS_W-1:0]          count
);
	import ialu_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	state_t                   state_q, state_d;
	logic [LW-1:0]            len_q, len_d;
	logic [IW-1:0]            cnt_q, cnt_d;
	logic                     done_q, done_d;
	logic                     status_q, status_d;
	logic signed [DATA_W-1:0] rd_q, rd_d;
	logic [POS_W-1:0]         count_q, count_d;

	cell_ctrl_t               ctrl;
	logic [CW-1:0]            cell_pos;
	logic [CW-1:0]            pos_x;
	logic [CW-1:0]            len_x;
	logic                     full;
	logic                     accept;

	logic signed [DATA_W-1:0] data_w [CAPACITY];
	logic signed [DATA_W-1:0] lane_w [CAPACITY];

	assign pos_x  = CW'(position);
	assign len_x  = CW'(len_q);
	assign full   = (len_x == CW'(CAPACITY));
	assign accept = start && (state_q == ST_IDLE);

	// Decode the command, pick the cell operation and form the result
	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		done_d     = 1'b0;
		status_d   = status_q;
		rd_d       = rd_q;
		count_d    = count_q;
		ctrl.cmd   = CMD_HOLD;
		ctrl.value = value;
		cell_pos   = pos_x;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					done_d   = 1'b1;
					status_d = 1'b0;
					rd_d     = '0;
					unique case (opcode_t'(opcode))
						OP_APPEND: begin
							if (full) begin
								status_d = 1'b1;
							end else begin
								ctrl.cmd = CMD_INSERT;
								cell_pos = len_x;
								len_d    = len_q + LW'(1);
							end
						end
						OP_INSERT: begin
							if (full || (pos_x > len_x)) begin
								status_d = 1'b1;
							end else begin
								ctrl.cmd = CMD_INSERT;
								len_d    = len_q + LW'(1);
							end
						end
						OP_POP: begin
							if (len_q == '0) begin
								status_d = 1'b1;
							end else begin
								len_d = len_q - LW'(1);
							end
						end
						OP_REMOVE: begin
							if (pos_x >= len_x) begin
								status_d = 1'b1;
							end else begin
								ctrl.cmd = CMD_REMOVE;
								len_d    = len_q - LW'(1);
							end
						end
						OP_READ: begin
							if (pos_x >= len_x) begin
								status_d = 1'b1;
							end else begin
								ctrl.cmd = CMD_LOAD;
								cnt_d    = pos_x[IW-1:0];
								state_d  = ST_READ;
								done_d   = 1'b0;
							end
						end
						default: begin
							status_d = 1'b1;
						end
					endcase
					count_d = POS_W'(len_d);
				end
			end
			ST_READ: begin
				if (cnt_q == '0) begin
					done_d   = 1'b1;
					status_d = 1'b0;
					rd_d     = lane_w[0];
					count_d  = POS_W'(len_q);
					state_d  = ST_IDLE;
				end else begin
					ctrl.cmd = CMD_SHIFT;
					cnt_d    = cnt_q - IW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state and the length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		status_q <= status_d;
		rd_q     <= rd_d;
		count_q  <= count_d;
	end

	// Row of cells, each wired to its neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [DATA_W-1:0] prev_d;
		logic signed [DATA_W-1:0] next_d;
		logic signed [DATA_W-1:0] next_l;

		if (g == 0) begin : g_head
			assign prev_d = '0;
		end else begin : g_body
			assign prev_d = data_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign next_d = '0;
			assign next_l = '0;
		end else begin : g_link
			assign next_d = data_w[g+1];
			assign next_l = lane_w[g+1];
		end

		ialu_cell #(
			.IDX_W (CW),
			.INDEX (g)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.pos       (cell_pos),
			.prev_data (prev_d),
			.next_data (next_d),
			.next_lane (next_l),
			.data      (data_w[g]),
			.lane      (lane_w[g])
		);
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign read_value = rd_q;
	assign count      = count_q;

endmodule

### hdl/ialu_checker.sv
// Port-level checker for the indexed array list engine, bound to the top level.
`timescale 1ns / 1ps
module ialu_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [ialu_pkg::OP_W-1:0]           opcode,
	input logic                                done,
	input logic                                status,
	input logic signed [ialu_pkg::DATA_W-1:0]  read_value
);
	import ialu_pkg::*;

	// A non-read transfer answers on the next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode != OP_READ)) |=> done)
		else $error("non-read command did not answer in one cycle");

	// Busy only starts after a read transfer
	a_busy_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (opcode == OP_READ)))
		else $error("busy rose without a read command");

	// Leaving a read walk delivers its result
	a_read_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && !status))
		else $error("read walk ended without a good result");

	// A rejected command reports zero read data
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (read_value == '0))
		else $error("rejected command carried read data");

	// No result while a read is still walking
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> !done)
		else $error("result strobe during read walk");

endmodule

bind indexed_array_list_engine_unit ialu_checker u_ialu_checker (.*);

### verif/indexed_array_list_engine_unit_test.sv
// Self-checking testbench for the indexed array list engine unit.
`timescale 1ns / 1ps
module indexed_array_list_engine_unit_test;
	import ialu_pkg::*;

	localparam int LIST_CAP     = 256;
	localparam int RANDOM_CMDS  = 1880;
	localparam int QUIET_TAIL   = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 3_000_000;

	localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
	localparam logic [POS_W-1:0]  POS_TOP  = '1;

	typedef struct {
		logic                     status;
		logic signed [DATA_W-1:0] read_value;
		logic [POS_W-1:0]         count;
	} list_reply_t;

	// Track the list contents and the replies still owed by the block.
	class list_tracker;
		logic signed [DATA_W-1:0] elems [LIST_CAP];
		int                       length;
		list_reply_t              owed_replies [$];
		int                       errors;
		int                       n_cmds;
		int                       n_rejected;
		int                       n_reads;
		int                       n_full;
		int                       n_empty;

		function new();
			length     = 0;
			errors     = 0;
			n_cmds     = 0;
			n_rejected = 0;
			n_reads    = 0;
			n_full     = 0;
			n_empty    = 0;
		endfunction

		// Apply one accepted command to the list and queue its reply.
		function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
				logic signed [DATA_W-1:0] val);
			list_reply_t r;
			int          i;
			r.status     = 1'b0;
			r.read_value = '0;
			case (op)
				OP_APPEND: begin
					if (length >= LIST_CAP) begin
						r.status = 1'b1;
						n_full++;
					end else begin
						elems[length] = val;
						length++;
					end
				end
				OP_INSERT: begin
					if (length >= LIST_CAP || int'(pos) > length) begin
						r.status = 1'b1;
						if (length >= LIST_CAP)
							n_full++;
					end else begin
						for (i = length; i > int'(pos); i--)
							elems[i] = elems[i-1];
						elems[pos] = val;
						length++;
					end
				end
				OP_POP: begin
					if (length == 0) begin
						r.status = 1'b1;
						n_empty++;
					end else begin
						length--;
					end
				end
				OP_REMOVE: begin
					if (length == 0 || int'(pos) >= length) begin
						r.status = 1'b1;
						if (length == 0)
							n_empty++;
					end else begin
						length--;
						for (i = int'(pos); i < length; i++)
							elems[i] = elems[i+1];
					end
				end
				OP_READ: begin
					if (int'(pos) >= length) begin
						r.status = 1'b1;
					end else begin
						r.read_value = elems[pos];
						n_reads++;
					end
				end
				default: begin
					r.status = 1'b1;
				end
			endcase
			r.count = POS_W'(length);
			n_cmds++;
			if (r.status)
				n_rejected++;
			owed_replies = {owed_replies, r};
		endfunction

		// Compare one reply from the block with the oldest owed reply.
		function void check_reply(logic st, logic signed [DATA_W-1:0] rd,
				logic [POS_W-1:0] cnt);
			list_reply_t want;
			if (owed_replies.size() == 0) begin
				$error("reply with none owed: status %0d read_value %0d count %0d",
					st, rd, cnt);
				errors++;
			end else begin
				want = owed_replies.pop_front();
				if (st !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, st);
					errors++;
				end
				if (rd !== want.read_value) begin
					$error("read_value: expected %0d, actual %0d", want.read_value, rd);
					errors++;
				end
				if (cnt !== want.count) begin
					$error("count: expected %0d, actual %0d", want.count, cnt);
					errors++;
				end
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [OP_W-1:0]          opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic                     status;
	logic signed [DATA_W-1:0] read_value;
	logic [POS_W-1:0]         count;
	int                       cycles = 0;
	list_tracker              sb = new();

	indexed_array_list_engine_unit #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.position  (position),
		.value     (value),
		.done      (done),
		.status    (status),
		.read_value(read_value),
		.count     (count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every reply on the cycle its strobe is up.
	always @(posedge clk) begin
		if (done)
			sb.check_reply(status, read_value, count);
	end

	// Give up on a hung block.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Hold one command until the block takes it, then maybe drop start for a burst.
	task automatic issue(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, input bit may_pause);
		start    <= 1'b1;
		opcode   <= op;
		position <= pos;
		value    <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(op, pos, val);
		if (may_pause && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return MOST_NEG;
			1:       return MOST_POS;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Swing the list between empty and full with legal commands, plus some noise.
	task automatic run_random(input int total);
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		bit                grow;
		bit                gaps;
		int                pick;
		int                len;
		grow = 1'b1;
		gaps = 1'b1;
		for (int k = 0; k < total; k++) begin
			len = sb.length;
			// linger a few commands at either end before turning around
			if ((len == LIST_CAP && grow) || (len == 0 && !grow)) begin
				if ($urandom_range(0, 3) == 0)
					grow = !grow;
			end else if ($urandom_range(0, 199) == 0) begin
				grow = !grow;
			end
			val  = pick_value();
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 12) begin
				// noise: any opcode, index at the edge or anywhere
				op = OP_W'($urandom_range(0, (1 << OP_W) - 1));
				if (pick < 50)
					pos = POS_W'(len + $urandom_range(0, 1));
				else
					pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
			end else begin
				if (pick < (grow ? 40 : 8))
					op = OP_APPEND;
				else if (pick < (grow ? 70 : 15))
					op = OP_INSERT;
				else if (pick < (grow ? 78 : 45))
					op = OP_POP;
				else if (pick < (grow ? 85 : 75))
					op = OP_REMOVE;
				else
					op = OP_READ;
				case (op)
					OP_INSERT:          pos = POS_W'($urandom_range(0, len));
					OP_REMOVE, OP_READ: pos = (len == 0) ? '0 :
							POS_W'($urandom_range(0, len - 1));
					default:            pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
				endcase
			end
			if (k % 97 == 0)
				gaps = ($urandom_range(0, 2) != 0);
			issue(op, pos, val, gaps && (k < total - QUIET_TAIL));
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		opcode   <= OP_APPEND;
		position <= '0;
		value    <= '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every removal and read bounces, insert past the end too
		issue(OP_POP, '0, '0, 1'b1);
		issue(OP_REMOVE, '0, '0, 1'b1);
		issue(OP_READ, '0, '0, 1'b1);
		issue(OP_INSERT, 9'd1, MOST_POS, 1'b1);
		// build a short list through every way in
		issue(OP_INSERT, '0, MOST_NEG, 1'b1);
		issue(OP_APPEND, POS_TOP, MOST_POS, 1'b1);
		issue(OP_INSERT, 9'd2, '0, 1'b1);
		issue(OP_INSERT, 9'd1, '1, 1'b1);
		issue(OP_READ, 9'd0, '0, 1'b0);
		issue(OP_READ, 9'd1, '0, 1'b0);
		issue(OP_READ, 9'd2, '0, 1'b1);
		issue(OP_READ, 9'd3, '0, 1'b1);
		// read at the length and at the top index
		issue(OP_READ, 9'd4, '0, 1'b1);
		issue(OP_READ, POS_TOP, '0, 1'b1);
		issue(OP_REMOVE, 9'd3, '0, 1'b1);
		issue(OP_REMOVE, 9'd0, '0, 1'b1);
		issue(OP_REMOVE, 9'd2, '0, 1'b1);
		// unused opcodes
		issue(OP_READ + 3'd1, POS_TOP, '1, 1'b1);
		issue(OP_READ + 3'd2, '0, MOST_NEG, 1'b1);
		issue(OP_READ + 3'd3, 9'd1, MOST_POS, 1'b1);
		issue(OP_POP, POS_TOP, '0, 1'b1);
		issue(OP_READ, '0, '0, 1'b1);
		issue(OP_POP, '0, '0, 1'b1);

		run_random(RANDOM_CMDS);

		// drain the last replies
		start <= 1'b0;
		while (sb.owed_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("%0d commands sent, %0d rejected, %0d reads returned an element",
			sb.n_cmds, sb.n_rejected, sb.n_reads);
		$display("%0d adds refused on a full list, %0d removals refused on an empty one",
			sb.n_full, sb.n_empty);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
